// ===== rtl/ddf_pkg.sv =====
// Shared types, constants and helpers of the decimal digit formatter.
`timescale 1ns / 1ps
package ddf_pkg;

   // Output form codes of the format register.
   typedef enum logic [1:0] {
      MODE_TWO_DIGIT  = 2'd0,
      MODE_FOUR_DIGIT = 2'd1,
      MODE_TENTHS     = 2'd2,
      MODE_HUNDREDTHS = 2'd3
   } mode_type;

   localparam int VALUE_W        = 16;
   localparam int CHAR_W         = 7;
   localparam int MAX_CHARS      = 5;
   localparam int CHAR_IDX_W     = 3;
   localparam int FRACTION_BITS_DEF = 8;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

   // One formatted value: up to five characters and the index of the final one.
   typedef struct packed {
      logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
      logic [CHAR_IDX_W-1:0]            last_idx;
   } chars_type;

   // ASCII code of one decimal digit.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      return CH_ZERO + CHAR_W'(d);
   endfunction

endpackage

// ===== rtl/ddf_pipe.sv =====
// Arithmetic pipeline: fixed-point scaling, saturation, digit split and character build.
`timescale 1ns / 1ps
module ddf_pipe #(
   parameter int FRACTION_BITS = ddf_pkg::FRACTION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [ddf_pkg::VALUE_W-1:0]  in_value,
   input  ddf_pkg::mode_type            in_mode,
   output logic                         out_valid,
   input  logic                         out_ready,
   output ddf_pkg::chars_type           out_data
);
   import ddf_pkg::*;

   localparam int NUM_STAGES = 5;
   // Widest scaled product: value * 100 plus the rounding half.
   localparam int PROD_W     = 23;
   localparam int SCALED_W   = 14;
   localparam int RECIP_W    = 28;
   localparam logic [PROD_W-1:0]   HALF      = PROD_W'(1) << (FRACTION_BITS - 1);
   localparam logic [SCALED_W-1:0] CAP_SMALL = 14'd99;
   localparam logic [SCALED_W-1:0] CAP_LARGE = 14'd9999;
   // Exact reciprocals for values up to 9999.
   localparam logic [RECIP_W-1:0]  RECIP_10   = 28'd6554;
   localparam logic [RECIP_W-1:0]  RECIP_100  = 28'd5243;
   localparam logic [RECIP_W-1:0]  RECIP_1000 = 28'd8389;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, adv;
   mode_type              mode_ff [NUM_STAGES-1];

   // Stage data.
   logic [PROD_W-1:0]   scaled_ff, scaled_in;
   logic [SCALED_W-1:0] sat_ff, sat_in;
   logic [SCALED_W-1:0] s3_ff;
   logic [9:0]          q10_ff, q10_in;
   logic [6:0]          q100_ff, q100_in;
   logic [3:0]          q1000_ff, q1000_in;
   logic [3:0][3:0]     dig_ff, dig_in;
   chars_type           chars_ff, chars_in;

   logic [PROD_W-1:0]  prod10, prod100;
   logic [RECIP_W-1:0] p10, p100, p1000;
   logic [SCALED_W-1:0] t0;
   logic [9:0]          t1;
   logic [6:0]          t2;
   logic                lead3, lead2, lead1;

   // Stall control: a stage moves when it is empty or its successor moves.
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (k == 0) begin
            valid_in[k] = adv[k] ? in_valid : valid_ff[k];
         end else begin
            valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_data  = chars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: scale fixed-point input to tenths or hundredths (half up), or pass it on.
   always_comb begin
      prod10  = PROD_W'(in_value) * PROD_W'(10);
      prod100 = PROD_W'(in_value) * PROD_W'(100);
      case (in_mode)
         MODE_TENTHS:     scaled_in = (prod10 + HALF) >> FRACTION_BITS;
         MODE_HUNDREDTHS: scaled_in = (prod100 + HALF) >> FRACTION_BITS;
         default:         scaled_in = PROD_W'(in_value);
      endcase
   end

   // Stage 2: clamp to the largest number the form can show.
   always_comb begin
      case (mode_ff[0])
         MODE_TWO_DIGIT, MODE_TENTHS: begin
            sat_in = (scaled_ff > PROD_W'(CAP_SMALL)) ? CAP_SMALL : scaled_ff[SCALED_W-1:0];
         end
         default: begin
            sat_in = (scaled_ff > PROD_W'(CAP_LARGE)) ? CAP_LARGE : scaled_ff[SCALED_W-1:0];
         end
      endcase
   end

   // Stage 3: quotients by 10, 100 and 1000 through reciprocal multiplication.
   always_comb begin
      p10      = RECIP_W'(sat_ff) * RECIP_10;
      p100     = RECIP_W'(sat_ff) * RECIP_100;
      p1000    = RECIP_W'(sat_ff) * RECIP_1000;
      q10_in   = p10[25:16];
      q100_in  = p100[25:19];
      q1000_in = p1000[26:23];
   end

   // Stage 4: individual digits from neighboring quotients.
   always_comb begin
      t0 = s3_ff - SCALED_W'(q10_ff) * SCALED_W'(10);
      t1 = q10_ff - 10'(q100_ff) * 10'd10;
      t2 = q100_ff - 7'(q1000_ff) * 7'd10;
      dig_in[0] = t0[3:0];
      dig_in[1] = t1[3:0];
      dig_in[2] = t2[3:0];
      dig_in[3] = q1000_ff;
   end

   // Stage 5: characters with blanking for the selected form.
   always_comb begin
      lead3 = (dig_ff[3] == 4'd0);
      lead2 = lead3 && (dig_ff[2] == 4'd0);
      lead1 = lead2 && (dig_ff[1] == 4'd0);
      chars_in = '0;
      case (mode_ff[3])
         MODE_TWO_DIGIT: begin
            chars_in.chars[0] = (dig_ff[1] == 4'd0) ? CH_SPACE : digit_char(dig_ff[1]);
            chars_in.chars[1] = digit_char(dig_ff[0]);
            chars_in.last_idx = CHAR_IDX_W'(1);
         end
         MODE_FOUR_DIGIT: begin
            chars_in.chars[0] = lead3 ? CH_SPACE : digit_char(dig_ff[3]);
            chars_in.chars[1] = lead2 ? CH_SPACE : digit_char(dig_ff[2]);
            chars_in.chars[2] = lead1 ? CH_SPACE : digit_char(dig_ff[1]);
            chars_in.chars[3] = digit_char(dig_ff[0]);
            chars_in.last_idx = CHAR_IDX_W'(3);
         end
         MODE_TENTHS: begin
            chars_in.chars[0] = digit_char(dig_ff[1]);
            chars_in.chars[1] = CH_POINT;
            chars_in.chars[2] = digit_char(dig_ff[0]);
            chars_in.last_idx = CHAR_IDX_W'(2);
         end
         default: begin
            chars_in.chars[0] = lead3 ? CH_SPACE : digit_char(dig_ff[3]);
            chars_in.chars[1] = digit_char(dig_ff[2]);
            chars_in.chars[2] = CH_POINT;
            chars_in.chars[3] = digit_char(dig_ff[1]);
            chars_in.chars[4] = digit_char(dig_ff[0]);
            chars_in.last_idx = CHAR_IDX_W'(4);
         end
      endcase
   end

   // Stage registers, loaded whenever the stage moves.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         scaled_ff  <= scaled_in;
         mode_ff[0] <= in_mode;
      end
      if (adv[1]) begin
         sat_ff     <= sat_in;
         mode_ff[1] <= mode_ff[0];
      end
      if (adv[2]) begin
         s3_ff      <= sat_ff;
         q10_ff     <= q10_in;
         q100_ff    <= q100_in;
         q1000_ff   <= q1000_in;
         mode_ff[2] <= mode_ff[1];
      end
      if (adv[3]) begin
         dig_ff     <= dig_in;
         mode_ff[3] <= mode_ff[2];
      end
      if (adv[4]) begin
         chars_ff   <= chars_in;
      end
   end

endmodule

// ===== rtl/ddf_ser.sv =====
// Output buffer that sends the characters of one value one at a time.
`timescale 1ns / 1ps
module ddf_ser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ddf_pkg::chars_type          in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [ddf_pkg::CHAR_W-1:0]  out_character,
   output logic                        out_last
);
   import ddf_pkg::*;

   chars_type             buf_ff, buf_in;
   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic                  full_ff, full_in;
   logic                  load, send;

   assign out_valid     = full_ff;
   assign out_last      = (idx_ff == buf_ff.last_idx);
   assign out_character = buf_ff.chars[idx_ff];
   assign send          = full_ff && out_ready;
   assign in_ready      = !full_ff || (out_ready && out_last);
   assign load          = in_valid && in_ready;

   // Next buffer contents and character pointer.
   always_comb begin
      buf_in  = buf_ff;
      idx_in  = idx_ff;
      full_in = full_ff;
      if (load) begin
         buf_in  = in_data;
         idx_in  = '0;
         full_in = 1'b1;
      end else if (send) begin
         if (out_last) begin
            full_in = 1'b0;
         end else begin
            idx_in = idx_ff + CHAR_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      idx_ff <= idx_in;
   end

endmodule

// ===== rtl/decimal_digit_formatter.sv =====
// Top level of the decimal digit formatter: format register, pipeline and output buffer.
//
// Usage: each request on req_value is turned into ASCII display characters that
// leave one per accepted response on rsp_character, with rsp_last high on the
// final one. The form follows the format register set by csr_write_data (0 two
// digits, 1 four digits, 2 x.x, 3 xx.xx); it is captured with each request, and
// writing it takes effect on the next cycle. A value gives 2, 3, 4 or 5 characters.
// The first character of a request passes five register stages, which do scaling,
// clamping, the digit split and character selection, and then the output buffer,
// which holds one value. Requests may enter every cycle while the pipeline does
// not stall; output is bounded by the single response channel, which sends a
// value's characters one at a time (five in the xx.xx form), and the buffer takes
// the next value as the final character of the current one leaves.
// Reset clears all pipeline valid bits and the output buffer and sets the
// format to four digits. When the receiver holds rsp_ready low, the current
// character stays unchanged and the pipeline keeps filling until all five
// stages hold a request, after which req_ready drops; nothing is lost.
`timescale 1ns / 1ps
module decimal_digit_formatter #(
   parameter int FRACTION_BITS = ddf_pkg::FRACTION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ddf_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ddf_pkg::CHAR_W-1:0]   rsp_character,
   output logic                         rsp_last,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_write_data
);
   import ddf_pkg::*;

   mode_type  mode_ff, mode_in;
   logic      pipe_valid, ser_ready;
   chars_type pipe_data;

   // Format register.
   always_comb begin
      mode_in = mode_ff;
      if (csr_write_enable) begin
         mode_in = mode_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FOUR_DIGIT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   ddf_pipe #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value),
      .in_mode   (mode_ff),
      .out_valid (pipe_valid),
      .out_ready (ser_ready),
      .out_data  (pipe_data)
   );

   ddf_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pipe_valid),
      .in_ready      (ser_ready),
      .in_data       (pipe_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_character (rsp_character),
      .out_last      (rsp_last)
   );

   // Every character shown is a digit, a space or a point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CH_SPACE || rsp_character == CH_POINT ||
                     (rsp_character >= CH_ZERO && rsp_character <= CH_ZERO + 7'd9)))
      else $error("unexpected character code on the response");

   // A value whose final character has not gone out keeps the response valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("response dropped in the middle of a value");

   // After the final character with nothing loaded, the buffer is empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last && !pipe_valid |=> !rsp_valid)
      else $error("response repeated after the final character");

   // The pipeline hands a value over only as the buffer frees up, and it is then shown.
   assert property (@(posedge clock) disable iff (reset)
      pipe_valid && ser_ready |=> rsp_valid)
      else $error("loaded value not presented on the response");

endmodule

// ===== dv/decimal_digit_formatter_tb.sv =====
// Self-checking testbench of the decimal digit formatter with a character scoreboard.
`timescale 1ns / 1ps
module decimal_digit_formatter_tb;
   import ddf_pkg::*;

   localparam int FRAC_BITS = FRACTION_BITS_DEF;
   localparam int RANDOM_PER_SEGMENT = 49;
   localparam int LONG_HOLD_CYCLES = 120;

   // One display character as it should leave the response channel.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } display_char_type;

   // Scoreboard: turns each accepted request into the expected characters and
   // checks every response against the oldest one waiting.
   class digit_scoreboard;
      mode_type         mode;
      display_char_type expected_chars[$];
      int               errors;

      function new();
         mode = MODE_FOUR_DIGIT;
         errors = 0;
      endfunction

      function void set_mode(input logic [1:0] m);
         mode = mode_type'(m);
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function logic [CHAR_W-1:0] dec_char(input int unsigned d);
         return CH_ZERO + CHAR_W'(d % 10);
      endfunction

      function void push_char(input logic [CHAR_W-1:0] c, input logic l);
         display_char_type rec;
         rec.character = c;
         rec.last = l;
         expected_chars.push_back(rec);
      endfunction

      // Formats one request in the current mode, with saturation and rounding.
      function void note_request(input logic [VALUE_W-1:0] value);
         int unsigned v;
         int unsigned s;
         int unsigned d;
         bit          lead;
         v = int'(value);
         case (mode)
            MODE_TWO_DIGIT: begin
               s = (v > 99) ? 99 : v;
               d = s / 10;
               push_char((d == 0) ? CH_SPACE : dec_char(d), 1'b0);
               push_char(dec_char(s), 1'b1);
            end
            MODE_FOUR_DIGIT: begin
               s = (v > 9999) ? 9999 : v;
               lead = 1;
               d = s / 1000;
               if (d != 0) lead = 0;
               push_char(lead ? CH_SPACE : dec_char(d), 1'b0);
               d = (s / 100) % 10;
               if (d != 0) lead = 0;
               push_char(lead ? CH_SPACE : dec_char(d), 1'b0);
               d = (s / 10) % 10;
               if (d != 0) lead = 0;
               push_char(lead ? CH_SPACE : dec_char(d), 1'b0);
               push_char(dec_char(s), 1'b1);
            end
            MODE_TENTHS: begin
               // Round half up to tenths, then clamp at 9.9.
               s = (v * 10 + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
               if (s > 99) s = 99;
               push_char(dec_char(s / 10), 1'b0);
               push_char(CH_POINT, 1'b0);
               push_char(dec_char(s), 1'b1);
            end
            default: begin
               // Round half up to hundredths, then clamp at 99.99.
               s = (v * 100 + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
               if (s > 9999) s = 9999;
               d = s / 1000;
               push_char((d == 0) ? CH_SPACE : dec_char(d), 1'b0);
               push_char(dec_char(s / 100), 1'b0);
               push_char(CH_POINT, 1'b0);
               push_char(dec_char(s / 10), 1'b0);
               push_char(dec_char(s), 1'b1);
            end
         endcase
      endfunction

      function void check_response(input logic [CHAR_W-1:0] character, input logic last);
         display_char_type exp;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected response: expected none, got character %h last %b",
                     $time, character, last);
            errors++;
            return;
         end
         exp = expected_chars.pop_front();
         if (character !== exp.character) begin
            $display("%0t: character mismatch: expected %h, got %h",
                     $time, exp.character, character);
            errors++;
         end
         if (last !== exp.last) begin
            $display("%0t: last mismatch: expected %b, got %b", $time, exp.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;
   logic                csr_write_enable;
   logic [1:0]          csr_write_data;

   digit_scoreboard sb = new();

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   bit          long_hold_pending;

   // Directed requests: mode and value, covering blanking, rounding and saturation.
   logic [17:0] directed_items [26] = '{
      {MODE_FOUR_DIGIT, 16'd0},     {MODE_FOUR_DIGIT, 16'd5},
      {MODE_FOUR_DIGIT, 16'd10},    {MODE_FOUR_DIGIT, 16'd100},
      {MODE_FOUR_DIGIT, 16'd1000},  {MODE_FOUR_DIGIT, 16'd9999},
      {MODE_FOUR_DIGIT, 16'd10000}, {MODE_FOUR_DIGIT, 16'hFFFF},
      {MODE_TWO_DIGIT, 16'd0},      {MODE_TWO_DIGIT, 16'd9},
      {MODE_TWO_DIGIT, 16'd10},     {MODE_TWO_DIGIT, 16'd99},
      {MODE_TWO_DIGIT, 16'd100},
      {MODE_TENTHS, 16'd0},         {MODE_TENTHS, 16'd12},
      {MODE_TENTHS, 16'd13},        {MODE_TENTHS, 16'd64},
      {MODE_TENTHS, 16'h0980},      {MODE_TENTHS, 16'h09F3},
      {MODE_TENTHS, 16'hFFFF},
      {MODE_HUNDREDTHS, 16'd0},     {MODE_HUNDREDTHS, 16'd32},
      {MODE_HUNDREDTHS, 16'h0A00},  {MODE_HUNDREDTHS, 16'h63FF},
      {MODE_HUNDREDTHS, 16'h6400},  {MODE_HUNDREDTHS, 16'hFFFF}
   };

   mode_type segment_modes [8] = '{
      MODE_TWO_DIGIT, MODE_FOUR_DIGIT, MODE_TENTHS, MODE_HUNDREDTHS,
      MODE_HUNDREDTHS, MODE_TENTHS, MODE_FOUR_DIGIT, MODE_TWO_DIGIT
   };

   decimal_digit_formatter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog against a hung handshake.
   initial begin
      #1000000;
      $display("status: fail");
      $finish;
   end

   // Monitor: responses are checked before the same edge's request is noted,
   // and a format write only affects later requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_character, rsp_last);
         if (req_valid && req_ready) sb.note_request(req_value);
         if (csr_write_enable) sb.set_mode(csr_write_data);
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int unsigned held;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   // Offers one request after random idle cycles and waits until it is taken.
   task automatic send_request(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the input off until every expected character has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Format writes happen only with the block empty.
   task automatic write_format(input mode_type m);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly in-range values for the mode, with full-width and single-bit values mixed in.
   function automatic logic [VALUE_W-1:0] random_value(input mode_type m);
      int unsigned pick;
      pick = $urandom_range(9, 0);
      if (pick < 2) return VALUE_W'($urandom);
      if (pick == 2) return 16'h0001 << $urandom_range(15, 0);
      case (m)
         MODE_TWO_DIGIT:  return VALUE_W'($urandom_range(110, 0));
         MODE_FOUR_DIGIT: return VALUE_W'($urandom_range(10100, 0));
         MODE_TENTHS:     return VALUE_W'($urandom_range(16'h0A10, 0));
         default:         return VALUE_W'($urandom_range(16'h6410, 0));
      endcase
   endfunction

   // Main sequence: reset, directed requests, then random segments per mode.
   initial begin : stimulus
      mode_type current_mode;
      mode_type item_mode;
      int       seg;
      int       n;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_value        <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      long_hold_pending  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part starts in the reset format.
      current_mode = MODE_FOUR_DIGIT;
      for (n = 0; n < 26; n++) begin
         item_mode = mode_type'(directed_items[n][17:16]);
         if (item_mode != current_mode) begin
            write_format(item_mode);
            current_mode = item_mode;
         end
         send_request(directed_items[n][15:0]);
      end

      // Random segments, each with its own format and idling pattern.
      for (seg = 0; seg < 8; seg++) begin
         current_mode = segment_modes[seg];
         write_format(current_mode);
         case (seg % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 76;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 76;
            end
            default: begin
               sender_idle_pct = 21;
               receiver_stall_pct = 21;
            end
         endcase
         // Fill the pipeline against a stalled receiver so the input backs up.
         if (seg == 4) long_hold_pending = 1;
         for (n = 0; n < RANDOM_PER_SEGMENT; n++) send_request(random_value(current_mode));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ddf_pkg.sv
rtl/ddf_pipe.sv
rtl/ddf_ser.sv
rtl/decimal_digit_formatter.sv
dv/decimal_digit_formatter_tb.sv
